@@ hw/rtl/jaoc_pkg.sv @@
`default_nettype none
package jaoc_pkg;

   localparam int JOINT_COUNT = 32;
   localparam int TRIALS      = 5;

   localparam int ADC_MAX   = 4095;
   localparam int FULL_TURN = 360;

   localparam int CMD_W    = 1;
   localparam int JOINT_W  = 5;
   localparam int SAMPLE_W = 16;
   localparam int ANGLE_W  = 9;
   localparam int ADC_W    = 12;

   localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam int SUM_W  = $clog2(TRIALS * FULL_TURN + 1);
   localparam int CNT_W  = (TRIALS > 1) ? $clog2(TRIALS) : 1;

   // reciprocal for the trial average, corrected by one compare afterwards
   localparam int DIV_K     = 16;
   localparam int DIV_RECIP = (1 << DIV_K) / TRIALS;

   localparam logic CMD_MEASURE   = 1'b0;
   localparam logic CMD_CALIBRATE = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [JOINT_W-1:0] joint;
      logic [ANGLE_W-1:0] angle;
   } angle_item_type;

endpackage
`default_nettype wire

@@ hw/rtl/jaoc_if.sv @@
`default_nettype none
interface jaoc_req_if;
   import jaoc_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [JOINT_W-1:0]  joint;
   logic [SAMPLE_W-1:0] adc_sample;

   modport source (output valid, output cmd, output joint, output adc_sample, input ready);
   modport sink (input valid, input cmd, input joint, input adc_sample, output ready);
endinterface

interface jaoc_rsp_if;
   import jaoc_pkg::*;

   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] angle;
   logic               offset_written;

   modport source (output valid, output angle, output offset_written, input ready);
   modport sink (input valid, input angle, input offset_written, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/joint_angle_offset_calibrator.sv @@
// Joint angle converter with averaged per-joint zero offset.
// Request channel req_ch carries cmd, joint and a raw adc_sample; the sample
// is clamped to 4095 and scaled to 0..360 degrees. A calibrate request adds
// the angle to the joint's trial sum; every fifth one stores the truncated
// average as the joint's zero offset and raises offset_written. A measure
// request returns the angle corrected by that offset, modulo 360.
// Response channel rsp_ch returns exactly one response per request, in order.
// The request passes through the input register, the angle register and
// the result register before its response is valid.
// Throughput: one request per cycle unless rsp_ch stalls; the offset,
// sum and count tables are read and written in the result stage only,
// so requests to the same joint may follow each other in consecutive cycles.
// Reset clears the pipeline valid bits and all offsets, sums and counts.
// When the receiver stalls, the response holds and the stages behind it
// keep filling; req_ch.ready drops once all three are full.
`default_nettype none
module joint_angle_offset_calibrator (
   input  wire        clock,
   input  wire        reset,
   jaoc_req_if.sink   req_ch,
   jaoc_rsp_if.source rsp_ch
);
   import jaoc_pkg::*;

   logic           stg_valid;
   logic           stg_ready;
   angle_item_type stg_item;

   jaoc_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .stg_valid (stg_valid),
      .stg_ready (stg_ready),
      .stg_item  (stg_item)
   );

   jaoc_update u_update (
      .clock     (clock),
      .reset     (reset),
      .stg_valid (stg_valid),
      .stg_ready (stg_ready),
      .stg_item  (stg_item),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

@@ hw/rtl/jaoc_convert.sv @@
`default_nettype none
module jaoc_convert (
   input  wire                      clock,
   input  wire                      reset,
   jaoc_req_if.sink                 req_ch,
   output logic                     stg_valid,
   input  wire                      stg_ready,
   output jaoc_pkg::angle_item_type stg_item
);
   import jaoc_pkg::*;

   localparam int PROD_W = $clog2(ADC_MAX * FULL_TURN + ADC_MAX / 2 + 1);
   localparam int EST_W  = PROD_W - ADC_W;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic                in_cmd_ff;
   logic [JOINT_W-1:0]  in_joint_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                ang_valid_ff;
   logic                ang_valid_in;
   angle_item_type      ang_item_ff;
   angle_item_type      ang_item_in;

   logic                in_load;
   logic                ang_load;
   logic [ADC_W-1:0]    clamped;
   logic [PROD_W-1:0]   prod;
   logic [EST_W-1:0]    est;
   logic [PROD_W-1:0]   est_back;
   logic [PROD_W-1:0]   rem;

   assign ang_load     = !ang_valid_ff || stg_ready;
   assign in_load      = !in_valid_ff || ang_load;
   assign req_ch.ready = in_load;

   assign in_valid_in  = in_load ? req_ch.valid : in_valid_ff;
   assign ang_valid_in = ang_load ? in_valid_ff : ang_valid_ff;

   // round(sample * 360 / 4095): estimate with a shift, then one correction step
   always_comb begin
      clamped = (in_sample_ff > SAMPLE_W'(ADC_MAX)) ? ADC_W'(ADC_MAX) : in_sample_ff[ADC_W-1:0];
      prod = PROD_W'(clamped) * PROD_W'(FULL_TURN) + PROD_W'(ADC_MAX / 2);
      est = prod[PROD_W-1:ADC_W];
      est_back = PROD_W'({est, {ADC_W{1'b0}}}) - PROD_W'(est);
      rem = prod - est_back;
      ang_item_in.cmd = in_cmd_ff;
      ang_item_in.joint = in_joint_ff;
      ang_item_in.angle = ANGLE_W'(est) + ((rem >= PROD_W'(ADC_MAX)) ? ANGLE_W'(1) : ANGLE_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         ang_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         ang_valid_ff <= ang_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_cmd_ff    <= req_ch.cmd;
         in_joint_ff  <= req_ch.joint;
         in_sample_ff <= req_ch.adc_sample;
      end
      if (ang_load) begin
         ang_item_ff <= ang_item_in;
      end
   end

   assign stg_valid = ang_valid_ff;
   assign stg_item  = ang_item_ff;

endmodule
`default_nettype wire

@@ hw/rtl/jaoc_update.sv @@
`default_nettype none
module jaoc_update (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      stg_valid,
   output logic                     stg_ready,
   input  jaoc_pkg::angle_item_type stg_item,
   jaoc_rsp_if.source               rsp_ch
);
   import jaoc_pkg::*;

   localparam int DIV_W  = SUM_W + DIV_K + 1;
   localparam int WRAP_W = ANGLE_W + 1;

   logic [ANGLE_W-1:0] offset_ff [JOINT_COUNT];
   logic [SUM_W-1:0]   sum_ff    [JOINT_COUNT];
   logic [CNT_W-1:0]   count_ff  [JOINT_COUNT];
   logic [ANGLE_W-1:0] offset_in;
   logic [SUM_W-1:0]   sum_in;
   logic [CNT_W-1:0]   count_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [ANGLE_W-1:0] rsp_angle_ff;
   logic [ANGLE_W-1:0] rsp_angle_in;
   logic               rsp_written_ff;
   logic               rsp_written_in;

   logic               fire;
   logic               joint_ok;
   logic               calibrate;
   logic               last;
   logic               state_we;
   logic [JIDX_W-1:0]  idx;
   logic [SUM_W-1:0]   sum_new;
   logic [DIV_W-1:0]   div_prod;
   logic [SUM_W-1:0]   q_est;
   logic [SUM_W-1:0]   q_rem;
   logic [SUM_W-1:0]   avg;
   logic [ANGLE_W-1:0] off_sel;
   logic [WRAP_W-1:0]  wrap;
   logic [WRAP_W-1:0]  corrected;

   assign stg_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = stg_valid && stg_ready;
   assign rsp_valid_in = stg_ready ? stg_valid : rsp_valid_ff;

   assign joint_ok  = 32'(stg_item.joint) < JOINT_COUNT;
   assign idx       = JIDX_W'(stg_item.joint);
   assign calibrate = stg_item.cmd == CMD_CALIBRATE;

   always_comb begin
      sum_new = (joint_ok ? sum_ff[idx] : SUM_W'(0)) + SUM_W'(stg_item.angle);
      last = joint_ok && (count_ff[idx] == CNT_W'(TRIALS - 1));

      // sum / TRIALS by reciprocal, the estimate is low by at most one
      div_prod = DIV_W'(sum_new) * DIV_W'(DIV_RECIP);
      q_est = div_prod[DIV_K+SUM_W-1:DIV_K];
      q_rem = sum_new - SUM_W'(q_est * SUM_W'(TRIALS));
      avg = q_est + ((q_rem >= SUM_W'(TRIALS)) ? SUM_W'(1) : SUM_W'(0));

      offset_in = joint_ok ? offset_ff[idx] : ANGLE_W'(0);
      sum_in = sum_new;
      count_in = joint_ok ? (count_ff[idx] + CNT_W'(1)) : CNT_W'(0);
      if (last) begin
         offset_in = ANGLE_W'(avg);
         sum_in = SUM_W'(0);
         count_in = CNT_W'(0);
      end

      // angle 360 with offset 0 lands on twice a turn and wraps to 0
      off_sel = joint_ok ? offset_ff[idx] : ANGLE_W'(0);
      wrap = WRAP_W'(stg_item.angle) + WRAP_W'(FULL_TURN) - WRAP_W'(off_sel);
      if (wrap >= WRAP_W'(2 * FULL_TURN)) begin
         corrected = wrap - WRAP_W'(2 * FULL_TURN);
      end else if (wrap >= WRAP_W'(FULL_TURN)) begin
         corrected = wrap - WRAP_W'(FULL_TURN);
      end else begin
         corrected = wrap;
      end

      state_we = fire && joint_ok && calibrate;
      rsp_angle_in = calibrate ? stg_item.angle : ANGLE_W'(corrected);
      rsp_written_in = calibrate && last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < JOINT_COUNT; i++) begin
            offset_ff[i] <= '0;
            sum_ff[i]    <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (state_we) begin
            offset_ff[idx] <= offset_in;
            sum_ff[idx]    <= sum_in;
            count_ff[idx]  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready) begin
         rsp_angle_ff   <= rsp_angle_in;
         rsp_written_ff <= rsp_written_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.angle          = rsp_angle_ff;
   assign rsp_ch.offset_written = rsp_written_ff;

endmodule
`default_nettype wire
